// ===== sv/fim_pkg.sv =====
package fim_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  localparam logic [31:0] SRAM_LOW_RST  = 32'h2000_0000;
  localparam logic [31:0] SRAM_HIGH_RST = 32'h2002_0000;

  // header word positions
  localparam logic [2:0] HPOS_MAGIC   = 3'd0;
  localparam logic [2:0] HPOS_VERSION = 3'd1;
  localparam logic [2:0] HPOS_SIZE    = 3'd2;
  localparam logic [2:0] HPOS_ADDR    = 3'd3;
  localparam logic [2:0] HPOS_IMG_CRC = 3'd4;
  localparam logic [2:0] HPOS_HDR_CRC = 3'd7;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_MAGIC   = 3'd1;
  localparam logic [2:0] ST_VERSION = 3'd2;
  localparam logic [2:0] ST_SIZE    = 3'd3;
  localparam logic [2:0] ST_ADDR    = 3'd4;
  localparam logic [2:0] ST_HDR_CRC = 3'd5;
  localparam logic [2:0] ST_IMG_CRC = 3'd6;
  localparam logic [2:0] ST_VECTOR  = 3'd7;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_MAGIC     = 3'd0;
  localparam logic [2:0] REG_MAJOR     = 3'd1;
  localparam logic [2:0] REG_MAX_SIZE  = 3'd2;
  localparam logic [2:0] REG_APP_BASE  = 3'd3;
  localparam logic [2:0] REG_APP_SIZE  = 3'd4;
  localparam logic [2:0] REG_SRAM_LOW  = 3'd5;
  localparam logic [2:0] REG_SRAM_HIGH = 3'd6;

  typedef struct packed {
    logic [31:0] expected_magic;
    logic [15:0] major_version;
    logic [31:0] max_image_size;
    logic [31:0] app_region_base;
    logic [31:0] region_span;
    logic [31:0] sram_low;
    logic [31:0] sram_high;
  } cfg_t;

  typedef struct packed {
    logic        emit;
    logic [2:0]  status;
    logic [31:0] crc;
  } res_t;

  typedef logic [31:0][31:0] crc_cols_t;

  // 32 bit-steps of the reflected CRC on one word; used at elaboration only
  function automatic logic [31:0] crc_shift32(logic [31:0] v);
    logic [31:0] r;
    r = v;
    for (int k = 0; k < 32; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic crc_cols_t crc_cols();
    crc_cols_t c;
    for (int i = 0; i < 32; i++) begin
      c[i] = crc_shift32(32'h1 << i);
    end
    return c;
  endfunction

endpackage

// ===== sv/fim_crc32.sv =====
module fim_crc32 (
  input  logic [31:0] crc_i,
  input  logic [31:0] word_i,
  output logic [31:0] crc_o
);

  localparam fim_pkg::crc_cols_t COLS = fim_pkg::crc_cols();

  logic [31:0] v;

  assign v = crc_i ^ word_i;

  // CRC over one word is linear: XOR of the columns picked by each bit
  always_comb begin
    crc_o = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        crc_o = crc_o ^ COLS[i];
      end
    end
  end

endmodule

// ===== sv/fim_cfg.sv =====
module fim_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output fim_pkg::cfg_t cfg_o
);

  fim_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [2:0]    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_magic  <= '0;
      cfg_q.major_version   <= '0;
      cfg_q.max_image_size  <= '0;
      cfg_q.app_region_base <= '0;
      cfg_q.region_span     <= '0;
      cfg_q.sram_low        <= fim_pkg::SRAM_LOW_RST;
      cfg_q.sram_high       <= fim_pkg::SRAM_HIGH_RST;
    end else if (wr_en) begin
      unique case (idx)
        fim_pkg::REG_MAGIC:     cfg_q.expected_magic  <= pwdata;
        fim_pkg::REG_MAJOR:     cfg_q.major_version   <= pwdata[15:0];
        fim_pkg::REG_MAX_SIZE:  cfg_q.max_image_size  <= pwdata;
        fim_pkg::REG_APP_BASE:  cfg_q.app_region_base <= pwdata;
        fim_pkg::REG_APP_SIZE:  cfg_q.region_span     <= pwdata;
        fim_pkg::REG_SRAM_LOW:  cfg_q.sram_low        <= pwdata;
        fim_pkg::REG_SRAM_HIGH: cfg_q.sram_high       <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      fim_pkg::REG_MAGIC:     prdata = cfg_q.expected_magic;
      fim_pkg::REG_MAJOR:     prdata = {16'd0, cfg_q.major_version};
      fim_pkg::REG_MAX_SIZE:  prdata = cfg_q.max_image_size;
      fim_pkg::REG_APP_BASE:  prdata = cfg_q.app_region_base;
      fim_pkg::REG_APP_SIZE:  prdata = cfg_q.region_span;
      fim_pkg::REG_SRAM_LOW:  prdata = cfg_q.sram_low;
      fim_pkg::REG_SRAM_HIGH: prdata = cfg_q.sram_high;
      default:                prdata = '0;
    endcase
  end

endmodule

// ===== sv/fim_core.sv =====
module fim_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [31:0]   word_i,
  input  logic          last_i,
  input  fim_pkg::cfg_t cfg_i,
  output fim_pkg::res_t res_o
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_IMAGE  = 2'd1,
    PH_DRAIN  = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  pos_q, pos_d;
  logic [2:0]  fault_q, fault_d;
  logic [29:0] seen_q, seen_d;
  logic [31:0] hcrc_q, hcrc_d;
  logic [31:0] icrc_q, icrc_d;
  logic [29:0] total_q, total_d;
  logic [31:0] load_q, load_d;
  logic [31:0] exp_q, exp_d;
  logic [31:0] stack_q, stack_d;
  logic [31:0] rv_q, rv_d;

  logic [31:0] hcrc_cur, hcrc_next, icrc_next, icrc_fin;
  logic [2:0]  fault_cur;
  logic [29:0] seen_inc;
  logic [31:0] stack_eff, rv_eff;
  logic [32:0] region_top;

  assign hcrc_cur  = (pos_q == fim_pkg::HPOS_MAGIC) ? fim_pkg::CRC_ONES : hcrc_q;
  assign fault_cur = (pos_q == fim_pkg::HPOS_MAGIC) ? fim_pkg::ST_OK : fault_q;
  assign seen_inc  = seen_q + 30'd1;
  assign icrc_fin  = icrc_next ^ fim_pkg::CRC_ONES;
  assign stack_eff = (seen_q == 30'd0) ? word_i : stack_q;
  assign rv_eff    = (seen_q == 30'd1) ? word_i : rv_q;
  assign region_top = {1'b0, load_q} + {1'b0, cfg_i.region_span};

  fim_crc32 u_hdr_crc (
    .crc_i  (hcrc_cur),
    .word_i (word_i),
    .crc_o  (hcrc_next)
  );

  fim_crc32 u_img_crc (
    .crc_i  (icrc_q),
    .word_i (word_i),
    .crc_o  (icrc_next)
  );

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    fault_d = fault_q;
    seen_d  = seen_q;
    hcrc_d  = hcrc_q;
    icrc_d  = icrc_q;
    total_d = total_q;
    load_d  = load_q;
    exp_d   = exp_q;
    stack_d = stack_q;
    rv_d    = rv_q;
    res_o.emit   = 1'b0;
    res_o.status = fim_pkg::ST_OK;
    res_o.crc    = '0;

    unique case (phase_q)
      PH_HEADER: begin
        if (pos_q != fim_pkg::HPOS_HDR_CRC) begin
          hcrc_d  = hcrc_next;
          fault_d = fault_cur;
          case (pos_q)
            fim_pkg::HPOS_MAGIC: begin
              if (word_i != cfg_i.expected_magic && fault_cur == fim_pkg::ST_OK) begin
                fault_d = fim_pkg::ST_MAGIC;
              end
            end
            fim_pkg::HPOS_VERSION: begin
              if (word_i[31:16] != cfg_i.major_version && fault_cur == fim_pkg::ST_OK) begin
                fault_d = fim_pkg::ST_VERSION;
              end
            end
            fim_pkg::HPOS_SIZE: begin
              total_d = word_i[31:2];
              if ((word_i == 32'd0 || word_i > cfg_i.max_image_size || word_i[1:0] != 2'd0)
                  && fault_cur == fim_pkg::ST_OK) begin
                fault_d = fim_pkg::ST_SIZE;
              end
            end
            fim_pkg::HPOS_ADDR: begin
              load_d = word_i;
              if (word_i != cfg_i.app_region_base && fault_cur == fim_pkg::ST_OK) begin
                fault_d = fim_pkg::ST_ADDR;
              end
            end
            fim_pkg::HPOS_IMG_CRC: exp_d = word_i;
            default: ;
          endcase
          pos_d = pos_q + 3'd1;
          if (last_i) begin
            res_o.emit   = 1'b1;
            res_o.status = fim_pkg::ST_SIZE;
            pos_d        = '0;
          end
        end else begin
          pos_d = '0;
          if (fault_q != fim_pkg::ST_OK) begin
            res_o.emit   = 1'b1;
            res_o.status = fault_q;
            phase_d      = last_i ? PH_HEADER : PH_DRAIN;
          end else if ((hcrc_q ^ fim_pkg::CRC_ONES) != word_i) begin
            res_o.emit   = 1'b1;
            res_o.status = fim_pkg::ST_HDR_CRC;
            phase_d      = last_i ? PH_HEADER : PH_DRAIN;
          end else if (last_i) begin
            res_o.emit   = 1'b1;
            res_o.status = fim_pkg::ST_SIZE;
          end else begin
            phase_d = PH_IMAGE;
            icrc_d  = fim_pkg::CRC_ONES;
            seen_d  = '0;
            stack_d = '0;
            rv_d    = '0;
          end
        end
      end
      PH_IMAGE: begin
        icrc_d = icrc_next;
        seen_d = seen_inc;
        if (seen_q == 30'd0) begin
          stack_d = word_i;
        end
        if (seen_q == 30'd1) begin
          rv_d = word_i;
        end
        if (seen_inc == total_q) begin
          res_o.emit = 1'b1;
          res_o.crc  = icrc_fin;
          phase_d    = last_i ? PH_HEADER : PH_DRAIN;
          pos_d      = '0;
          if (icrc_fin != exp_q) begin
            res_o.status = fim_pkg::ST_IMG_CRC;
          end else if (stack_eff < cfg_i.sram_low || stack_eff > cfg_i.sram_high) begin
            res_o.status = fim_pkg::ST_VECTOR;
          end else if (!rv_eff[0]) begin
            res_o.status = fim_pkg::ST_VECTOR;
          end else if (rv_eff < load_q || {1'b0, rv_eff} >= region_top) begin
            res_o.status = fim_pkg::ST_VECTOR;
          end
        end else if (last_i) begin
          res_o.emit   = 1'b1;
          res_o.status = fim_pkg::ST_SIZE;
          phase_d      = PH_HEADER;
          pos_d        = '0;
        end
      end
      default: begin
        if (last_i) begin
          phase_d = PH_HEADER;
          pos_d   = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q   <= '0;
      fault_q <= '0;
      seen_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      fault_q <= fault_d;
      seen_q  <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      hcrc_q  <= hcrc_d;
      icrc_q  <= icrc_d;
      total_q <= total_d;
      load_q  <= load_d;
      exp_q   <= exp_d;
      stack_q <= stack_d;
      rv_q    <= rv_d;
    end
  end

endmodule

// ===== sv/firmware_image_verifier_unit.sv =====
// Firmware image verifier. Takes a word stream (eight header words, then the
// image words, tlast on the final word) and returns one result per stream:
// status in tdata[2:0] (0 ok, 1 magic, 2 version, 3 size or early end,
// 4 load address, 5 header CRC, 6 image CRC, 7 vector table) and the final
// image CRC-32 in tdata[34:3], zero when the image was not fully read.
// A header fault is reported on header word 7, an image result on the last
// declared image word; words after a result are dropped up to tlast.
// One word per cycle is accepted unless a new result meets a full output;
// the combinational 32-bit CRC step sits between the input register and
// the result register that holds each result. Registers sit at byte address
// 4*i (magic, major version, max size, region base, region size, SRAM low,
// SRAM high) and should only be written while idle.
module firmware_image_verifier_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] data_word
  input  logic        s_axis_tlast,   // last_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [2:0] status, [34:3] image_crc_value, [39:35] zero
);

  fim_pkg::cfg_t cfg;
  fim_pkg::res_t res;

  logic        in_valid_q;
  logic [31:0] in_word_q;
  logic        in_last_q;
  logic        out_valid_q;
  logic [34:0] out_data_q;
  logic        out_free;
  logic        advance;

  fim_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fim_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .word_i (in_word_q),
    .last_i (in_last_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (!res.emit || out_free);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_data_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance && res.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_word_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance && res.emit) begin
      out_data_q <= {res.crc, res.status};
    end
  end

endmodule
